### rtl/rpt_pkg.sv
// Shared types and constants for the RADIUS attribute parser.
package rpt_pkg;

  localparam int DefMaxPacketBytes = 4096;
  localparam int HdrBytes          = 20;
  localparam int AuthBytes         = 16;
  localparam int AuthStart         = 4;

  localparam logic [7:0] AttrLimitReset = 8'd50;

  localparam logic [3:0] KIND_CODE    = 4'd0;
  localparam logic [3:0] KIND_ID      = 4'd1;
  localparam logic [3:0] KIND_LEN_HI  = 4'd2;
  localparam logic [3:0] KIND_LEN_LO  = 4'd3;
  localparam logic [3:0] KIND_AUTH    = 4'd4;
  localparam logic [3:0] KIND_ATYPE   = 4'd5;
  localparam logic [3:0] KIND_ALEN    = 4'd6;
  localparam logic [3:0] KIND_VALUE   = 4'd7;
  localparam logic [3:0] KIND_IGNORED = 4'd8;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_BADLEN   = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_MANY     = 3'd4;
  localparam logic [2:0] ST_OVERSIZE = 3'd5;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_VALUE
  } phase_t;

  // Per-packet parse state, except the byte position whose width is parameterized.
  typedef struct packed {
    logic [7:0]  code_reg;
    logic [7:0]  ident_reg;
    logic [15:0] length_reg;
    logic [7:0]  attr_counter;
    logic [7:0]  cur_type;
    logic [7:0]  cur_len;
    logic [7:0]  value_index;
    phase_t      tlv_phase;
    logic [2:0]  error_code;
  } pkt_state_t;

  typedef struct packed {
    logic [3:0]  byte_kind;
    logic [7:0]  byte_echo;
    logic [7:0]  field_offset;
    logic [7:0]  attr_number;
    logic [7:0]  attr_kind;
    logic [7:0]  attr_size;
    logic        packet_done;
    logic [2:0]  status;
    logic [7:0]  packet_code;
    logic [7:0]  packet_ident;
    logic [15:0] declared_length;
    logic [7:0]  attr_count;
  } result_t;

endpackage

### rtl/rpt_if.sv
// Valid/ready channel interfaces for parser input bytes and results.
interface rpt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface rpt_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  byte_kind;
  logic [7:0]  byte_echo;
  logic [7:0]  field_offset;
  logic [7:0]  attr_number;
  logic [7:0]  attr_kind;
  logic [7:0]  attr_size;
  logic        packet_done;
  logic [2:0]  status;
  logic [7:0]  packet_code;
  logic [7:0]  packet_ident;
  logic [15:0] declared_length;
  logic [7:0]  attr_count;

  modport source (
    output valid, output byte_kind, output byte_echo, output field_offset,
    output attr_number, output attr_kind, output attr_size, output packet_done,
    output status, output packet_code, output packet_ident,
    output declared_length, output attr_count, input ready
  );
  modport sink (
    input valid, input byte_kind, input byte_echo, input field_offset,
    input attr_number, input attr_kind, input attr_size, input packet_done,
    input status, input packet_code, input packet_ident,
    input declared_length, input attr_count, output ready
  );
endinterface

### rtl/rpt_step.sv
// Byte classifier: next parse state and result for one packet byte.
module rpt_step
  import rpt_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = DefMaxPacketBytes,
  localparam int PosW = $clog2(MAX_PACKET_BYTES + 1)
) (
  input  pkt_state_t       st,
  input  logic [PosW-1:0]  pos,
  input  logic [7:0]       attr_limit,
  input  logic [7:0]       byte_value,
  input  logic             last_byte,
  output pkt_state_t       st_next,
  output logic [PosW-1:0]  pos_next,
  output result_t          res
);

  localparam logic [PosW-1:0] PosMax  = PosW'(MAX_PACKET_BYTES);
  localparam logic [PosW-1:0] PosAuthEnd = PosW'(AuthStart + AuthBytes);

  pkt_state_t upd;
  logic [3:0] kind;
  logic [7:0] offs;
  logic [7:0] vi_inc;

  always_comb begin
    upd    = st;
    kind   = KIND_IGNORED;
    offs   = 8'd0;
    vi_inc = st.value_index + 8'd1;

    if (st.error_code != ST_OK) begin
      kind = KIND_IGNORED;
    end else if (pos >= PosMax) begin
      upd.error_code = ST_OVERSIZE;
    end else if (pos == PosW'(0)) begin
      kind = KIND_CODE;
      upd.code_reg = byte_value;
    end else if (pos == PosW'(1)) begin
      kind = KIND_ID;
      upd.ident_reg = byte_value;
    end else if (pos == PosW'(2)) begin
      kind = KIND_LEN_HI;
      upd.length_reg[15:8] = byte_value;
    end else if (pos == PosW'(3)) begin
      kind = KIND_LEN_LO;
      upd.length_reg[7:0] = byte_value;
    end else if (pos < PosAuthEnd) begin
      kind = KIND_AUTH;
      offs = 8'(pos) - 8'(AuthStart);
    end else begin
      case (st.tlv_phase)
        PH_TYPE: begin
          if (st.attr_counter >= attr_limit) begin
            upd.error_code = ST_MANY;
          end else begin
            kind = KIND_ATYPE;
            upd.attr_counter = st.attr_counter + 8'd1;
            upd.cur_type     = byte_value;
            upd.cur_len      = 8'd0;
            upd.value_index  = 8'd0;
            upd.tlv_phase    = PH_LEN;
          end
        end
        PH_LEN: begin
          kind = KIND_ALEN;
          upd.cur_len     = byte_value;
          upd.value_index = 8'd0;
          if (byte_value < 8'd2) begin
            upd.error_code = ST_BADLEN;
          end else if (byte_value == 8'd2) begin
            upd.tlv_phase = PH_TYPE;
          end else begin
            upd.tlv_phase = PH_VALUE;
          end
        end
        default: begin
          kind = KIND_VALUE;
          offs = st.value_index;
          upd.value_index = vi_inc;
          if ({1'b0, vi_inc} + 9'd2 >= {1'b0, st.cur_len}) begin
            upd.tlv_phase = PH_TYPE;
          end
        end
      endcase
    end

    res.byte_kind    = kind;
    res.byte_echo    = byte_value;
    res.field_offset = offs;
    res.attr_number  = (upd.attr_counter != 8'd0) ? upd.attr_counter - 8'd1 : 8'd0;
    res.attr_kind    = upd.cur_type;
    res.attr_size    = upd.cur_len;
    res.packet_done     = 1'b0;
    res.status          = ST_OK;
    res.packet_code     = 8'd0;
    res.packet_ident    = 8'd0;
    res.declared_length = 16'd0;
    res.attr_count      = 8'd0;

    st_next  = upd;
    pos_next = (pos < PosMax) ? pos + PosW'(1) : pos;

    if (last_byte) begin
      res.packet_done = 1'b1;
      if (upd.error_code != ST_OK) begin
        res.status = upd.error_code;
      end else if (pos < PosW'(HdrBytes)) begin
        res.status = ST_SHORT;
      end else if (upd.tlv_phase != PH_TYPE) begin
        res.status = ST_TRUNC;
      end else begin
        res.status = ST_OK;
      end
      res.packet_code     = upd.code_reg;
      res.packet_ident    = upd.ident_reg;
      res.declared_length = upd.length_reg;
      res.attr_count      = upd.attr_counter;
      // Clear for the next packet.
      st_next  = '0;
      st_next.tlv_phase = PH_TYPE;
      pos_next = '0;
    end
  end

endmodule

### rtl/radius_packet_tlv_parser_unit.sv
// Top level of the RADIUS packet attribute parser.
//
//  channel     | dir | handshake    | payload
//  ------------+-----+--------------+--------------------------------------------
//  byte_in     | in  | valid/ready  | byte_value[7:0], last_byte
//  result_out  | out | valid/ready  | byte kind, attribute info, packet summary
//  cfg         | in  | cfg_we       | cfg_data[7:0] -> attr_limit
//
// One byte per cycle unless back-pressured; a result is valid the cycle after accept.
// The parse state updates in the accept cycle, so consecutive bytes need no gap.
// The result register holds under back-pressure; a new byte enters whenever the
// register is empty or being drained in the same cycle.
// rst (synchronous) clears the parse state, drops the result and sets attr_limit to 50.
module radius_packet_tlv_parser_unit
  import rpt_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = DefMaxPacketBytes
) (
  input  logic         clk,
  input  logic         rst,
  rpt_byte_if.sink     byte_in,
  rpt_result_if.source result_out,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_data
);

  localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);

  pkt_state_t      st;
  pkt_state_t      st_next;
  logic [PosW-1:0] pos;
  logic [PosW-1:0] pos_next;
  logic [7:0]      attr_limit;
  result_t         res_next;
  result_t         res;
  logic            res_valid;
  logic            accept;

  assign byte_in.ready = !res_valid || result_out.ready;
  assign accept        = byte_in.valid && byte_in.ready;

  rpt_step #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_step (
    .st         (st),
    .pos        (pos),
    .attr_limit (attr_limit),
    .byte_value (byte_in.byte_value),
    .last_byte  (byte_in.last_byte),
    .st_next    (st_next),
    .pos_next   (pos_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      // All-zero state includes PH_TYPE for the attribute phase.
      st           <= '0;
      pos          <= '0;
      attr_limit   <= AttrLimitReset;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr_limit <= cfg_data;
      end
      if (accept) begin
        st        <= st_next;
        pos       <= pos_next;
        res_valid <= 1'b1;
      end else if (result_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload register: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign result_out.valid           = res_valid;
  assign result_out.byte_kind       = res.byte_kind;
  assign result_out.byte_echo       = res.byte_echo;
  assign result_out.field_offset    = res.field_offset;
  assign result_out.attr_number     = res.attr_number;
  assign result_out.attr_kind       = res.attr_kind;
  assign result_out.attr_size       = res.attr_size;
  assign result_out.packet_done     = res.packet_done;
  assign result_out.status          = res.status;
  assign result_out.packet_code     = res.packet_code;
  assign result_out.packet_ident    = res.packet_ident;
  assign result_out.declared_length = res.declared_length;
  assign result_out.attr_count      = res.attr_count;

  a_pos_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && byte_in.last_byte |=> pos == '0 && st.error_code == ST_OK)
    else $error("packet state not cleared after final byte");

  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    pos <= PosW'(MAX_PACKET_BYTES))
    else $error("byte position beyond saturation point");

  a_ignored_after_error: assert property (@(posedge clk) disable iff (rst)
    accept && st.error_code != ST_OK |=> res.byte_kind == KIND_IGNORED)
    else $error("byte after error not tagged ignored");

  a_summary_zero_midpacket: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.packet_done |-> res.status == ST_OK && res.attr_count == 8'd0)
    else $error("summary fields set on a non-final result");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && !byte_in.last_byte && st.error_code != ST_OK
      |=> st.error_code == $past(st.error_code))
    else $error("first error overwritten within a packet");

endmodule
